// ===== sv/ffa_pkg.sv =====
// shared types, constants and codes of the first-fit block allocator
`timescale 1ns / 1ps

package ffa_pkg;

   // table and address geometry
   localparam int MAX_BLOCKS   = 64;
   localparam int IDX_BITS     = $clog2(MAX_BLOCKS);
   localparam int CNT_BITS     = IDX_BITS + 1;
   localparam int ADDR_BITS    = 20;
   localparam int LIMIT_BITS   = ADDR_BITS + 1;
   localparam int NEED_BITS    = LIMIT_BITS + 1;
   localparam int HEADER_BYTES = 16;

   typedef enum logic {
      MODE_ALLOC = 1'b0,
      MODE_FREE  = 1'b1
   } ffa_mode_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_ZERO    = 3'd1,
      ST_NOSPACE = 3'd2,
      ST_FULL    = 3'd3,
      ST_UNKNOWN = 3'd4
   } ffa_status_type;

   typedef struct packed {
      ffa_mode_type         mode;
      logic [ADDR_BITS-1:0] req_size;
      logic [ADDR_BITS-1:0] payload_address;
   } ffa_req_type;

   typedef struct packed {
      ffa_status_type       status;
      logic [ADDR_BITS-1:0] granted_address;
   } ffa_rsp_type;

   // one row of the block table
   typedef struct packed {
      logic                 is_free;
      logic [ADDR_BITS-1:0] size;
      logic [ADDR_BITS-1:0] start;
   } ffa_entry_type;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SCAN,
      OP_ALLOC_HIT,
      OP_SHIFT,
      OP_WR_TAIL,
      OP_GROW,
      OP_RD_NEXT,
      OP_CAP_NEXT,
      OP_FREE_WR,
      OP_POST
   } ffa_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_ALLOC_HIT,
      S_SPLIT_SHIFT,
      S_WR_TAIL,
      S_GROW,
      S_FREE_RD,
      S_FREE_CAP,
      S_FREE_WR,
      S_FREE_SHIFT,
      S_POST
   } ffa_state_type;

   typedef struct packed {
      ffa_op_type op;
   } ffa_cmd_type;

   typedef struct packed {
      logic zero_in;
      logic is_free_mode;
      logic scan_hit;
      logic scan_miss;
      logic hit_is_free;
      logic split_ok;
      logic shift_done;
      logic need_shift;
      logic out_free;
   } ffa_stat_type;

endpackage

// ===== sv/ffa_ram.sv =====
// generic single write, single read memory with registered read data
`timescale 1ns / 1ps

module ffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ffa_ctrl.sv =====
// controller state machine sequencing scan, split, grow, merge and reply
`timescale 1ns / 1ps

module ffa_ctrl import ffa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  ffa_stat_type stat,
   output ffa_cmd_type  cmd
);

   ffa_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = stat.zero_in ? S_POST : S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.op = OP_SCAN;
            if (stat.scan_hit) begin
               if (!stat.is_free_mode) begin
                  state_in = S_ALLOC_HIT;
               end else begin
                  state_in = stat.hit_is_free ? S_POST : S_FREE_RD;
               end
            end else if (stat.scan_miss) begin
               state_in = stat.is_free_mode ? S_POST : S_GROW;
            end
         end
         S_ALLOC_HIT: begin
            cmd.op   = OP_ALLOC_HIT;
            state_in = stat.split_ok ? S_SPLIT_SHIFT : S_POST;
         end
         S_SPLIT_SHIFT: begin
            cmd.op = OP_SHIFT;
            if (stat.shift_done) begin
               state_in = S_WR_TAIL;
            end
         end
         S_WR_TAIL: begin
            cmd.op   = OP_WR_TAIL;
            state_in = S_POST;
         end
         S_GROW: begin
            cmd.op   = OP_GROW;
            state_in = S_POST;
         end
         S_FREE_RD: begin
            cmd.op   = OP_RD_NEXT;
            state_in = S_FREE_CAP;
         end
         S_FREE_CAP: begin
            cmd.op   = OP_CAP_NEXT;
            state_in = S_FREE_WR;
         end
         S_FREE_WR: begin
            cmd.op   = OP_FREE_WR;
            state_in = stat.need_shift ? S_FREE_SHIFT : S_POST;
         end
         S_FREE_SHIFT: begin
            cmd.op = OP_SHIFT;
            if (stat.shift_done) begin
               state_in = S_POST;
            end
         end
         S_POST: begin
            if (stat.out_free) begin
               cmd.op   = OP_POST;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/ffa_dpath.sv =====
// datapath: block table, heap registers, scan and shift engine, result word
`timescale 1ns / 1ps

module ffa_dpath import ffa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  ffa_req_type           req_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [LIMIT_BITS-1:0] csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ffa_rsp_type           rsp_data,
   input  ffa_cmd_type           cmd,
   output ffa_stat_type          stat
);

   localparam logic [ADDR_BITS-1:0]  HDR       = ADDR_BITS'(HEADER_BYTES);
   localparam logic [LIMIT_BITS-1:0] LIMIT_CAP = LIMIT_BITS'(1) << ADDR_BITS;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RST = LIMIT_BITS'(1) << ADDR_BITS;
   localparam logic [CNT_BITS-1:0]   CNT_MAX   = CNT_BITS'(MAX_BLOCKS);
   localparam logic [CNT_BITS-1:0]   CNT_ONE   = CNT_BITS'(1);

   // control registers
   logic [LIMIT_BITS-1:0] limit_ff, limit_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [LIMIT_BITS-1:0] brk_ff, brk_in;
   logic                  rvalid_ff, rvalid_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // working registers
   ffa_mode_type          mode_ff, mode_in;
   logic [ADDR_BITS-1:0]  size_ff, size_in;
   logic [ADDR_BITS-1:0]  addr_ff, addr_in;
   logic [CNT_BITS-1:0]   rd_idx_ff, rd_idx_in;
   logic [CNT_BITS-1:0]   dat_idx_ff, dat_idx_in;
   logic [CNT_BITS-1:0]   idx_ff, idx_in;
   logic [CNT_BITS-1:0]   lo_ff, lo_in;
   logic [CNT_BITS-1:0]   hi_ff, hi_in;
   logic [1:0]            dist_ff, dist_in;
   logic                  shift_up_ff, shift_up_in;
   logic                  mr_ff, mr_in;
   ffa_entry_type         cur_ff, cur_in;
   ffa_entry_type         prv_ff, prv_in;
   ffa_entry_type         nxt_ff, nxt_in;
   ffa_status_type        res_status_ff, res_status_in;
   logic [ADDR_BITS-1:0]  res_grant_ff, res_grant_in;
   ffa_rsp_type           rsp_data_ff, rsp_data_in;

   // memory ports
   logic                  rd_en;
   logic [IDX_BITS-1:0]   rd_addr;
   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   ffa_entry_type         wr_data;
   logic [$bits(ffa_entry_type)-1:0] rd_word;
   ffa_entry_type         rd_data;

   // derived values
   logic                  hit_alloc, hit_free;
   logic                  issue_up, issue_dn;
   logic [CNT_BITS-1:0]   rd_dec, idx_inc;
   logic [CNT_BITS-1:0]   idx_dec, dat_inc, dat_dec;
   logic                  ml;
   logic [ADDR_BITS-1:0]  s_right, s_left;
   logic [LIMIT_BITS-1:0] lim_eff;
   logic [NEED_BITS-1:0]  need;
   logic                  out_free;

   ffa_ram #(
      .WIDTH ($bits(ffa_entry_type)),
      .DEPTH (MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_data   = ffa_entry_type'(rd_word);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // match tests and arithmetic
   always_comb begin
      hit_alloc = rd_data.is_free && (rd_data.size >= size_ff);
      hit_free  = ({1'b0, rd_data.start} + LIMIT_BITS'(HEADER_BYTES)) == {1'b0, addr_ff};
      rd_dec    = rd_idx_ff - CNT_ONE;
      idx_inc   = idx_ff + CNT_ONE;
      idx_dec   = idx_ff - CNT_ONE;
      dat_inc   = dat_idx_ff + CNT_ONE;
      dat_dec   = dat_idx_ff - CNT_BITS'(dist_ff);
      issue_up  = rd_idx_ff > lo_ff;
      issue_dn  = rd_idx_ff < hi_ff;
      ml        = (idx_ff != '0) && prv_ff.is_free;
      s_right   = mr_ff ? (cur_ff.size + HDR + nxt_ff.size) : cur_ff.size;
      s_left    = prv_ff.size + HDR + s_right;
      lim_eff   = (limit_ff > LIMIT_CAP) ? LIMIT_CAP : limit_ff;
      need      = NEED_BITS'(brk_ff) + NEED_BITS'(HEADER_BYTES) + NEED_BITS'(size_ff);
      out_free  = !rsp_valid_ff || !rsp_stall;
   end

   // status to the controller
   always_comb begin
      stat.zero_in      = (req_data.mode == MODE_ALLOC) && (req_data.req_size == '0);
      stat.is_free_mode = (mode_ff == MODE_FREE);
      stat.scan_hit     = rvalid_ff && ((mode_ff == MODE_FREE) ? hit_free : hit_alloc);
      stat.scan_miss    = !rvalid_ff && (rd_idx_ff >= count_ff);
      stat.hit_is_free  = rd_data.is_free;
      stat.split_ok     = ((cur_ff.size - size_ff) > HDR) && (count_ff < CNT_MAX);
      stat.shift_done   = !rvalid_ff && (shift_up_ff ? !issue_up : !issue_dn);
      stat.need_shift   = ml || mr_ff;
      stat.out_free     = out_free;
   end

   // next values per operation
   always_comb begin
      limit_in      = limit_ff;
      count_in      = count_ff;
      brk_in        = brk_ff;
      rvalid_in     = 1'b0;
      mode_in       = mode_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      rd_idx_in     = rd_idx_ff;
      dat_idx_in    = dat_idx_ff;
      idx_in        = idx_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      dist_in       = dist_ff;
      shift_up_in   = shift_up_ff;
      mr_in         = mr_ff;
      cur_in        = cur_ff;
      prv_in        = prv_ff;
      nxt_in        = nxt_ff;
      res_status_in = res_status_ff;
      res_grant_in  = res_grant_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rd_en         = 1'b0;
      rd_addr       = rd_idx_ff[IDX_BITS-1:0];
      wr_en         = 1'b0;
      wr_addr       = idx_ff[IDX_BITS-1:0];
      wr_data       = cur_ff;

      // register write
      if (csr_valid && csr_ready) begin
         limit_in = csr_data;
      end

      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_LOAD: begin
            mode_in       = req_data.mode;
            size_in       = req_data.req_size;
            addr_in       = req_data.payload_address;
            rd_idx_in     = '0;
            res_status_in = stat.zero_in ? ST_ZERO : ST_OK;
            res_grant_in  = '0;
         end
         OP_SCAN: begin
            rd_en      = rd_idx_ff < count_ff;
            rd_addr    = rd_idx_ff[IDX_BITS-1:0];
            rvalid_in  = rd_en;
            dat_idx_in = rd_idx_ff;
            if (rd_en) begin
               rd_idx_in = rd_idx_ff + CNT_ONE;
            end
            if (stat.scan_hit) begin
               cur_in = rd_data;
               idx_in = dat_idx_ff;
               if (mode_ff == MODE_ALLOC) begin
                  res_grant_in = rd_data.start + HDR;
               end
            end else if (rvalid_ff) begin
               prv_in = rd_data;
            end
            if (stat.scan_miss && (mode_ff == MODE_FREE)) begin
               res_status_in = ST_UNKNOWN;
            end
         end
         OP_ALLOC_HIT: begin
            wr_en           = 1'b1;
            wr_addr         = idx_ff[IDX_BITS-1:0];
            wr_data.is_free = 1'b0;
            wr_data.size    = stat.split_ok ? size_ff : cur_ff.size;
            wr_data.start   = cur_ff.start;
            if (stat.split_ok) begin
               rd_idx_in   = count_ff;
               lo_in       = idx_inc;
               shift_up_in = 1'b1;
               count_in    = count_ff + CNT_ONE;
            end
         end
         OP_SHIFT: begin
            // one entry read per cycle, written in the next cycle at its new place
            if (shift_up_ff) begin
               rd_en   = issue_up;
               rd_addr = rd_dec[IDX_BITS-1:0];
               if (issue_up) begin
                  rd_idx_in = rd_dec;
               end
               dat_idx_in = rd_dec;
               wr_addr    = dat_inc[IDX_BITS-1:0];
            end else begin
               rd_en   = issue_dn;
               rd_addr = rd_idx_ff[IDX_BITS-1:0];
               if (issue_dn) begin
                  rd_idx_in = rd_idx_ff + CNT_ONE;
               end
               dat_idx_in = rd_idx_ff;
               wr_addr    = dat_dec[IDX_BITS-1:0];
            end
            rvalid_in = rd_en;
            wr_en     = rvalid_ff;
            wr_data   = rd_data;
         end
         OP_WR_TAIL: begin
            wr_en           = 1'b1;
            wr_addr         = idx_inc[IDX_BITS-1:0];
            wr_data.is_free = 1'b1;
            wr_data.size    = cur_ff.size - size_ff - HDR;
            wr_data.start   = cur_ff.start + HDR + size_ff;
         end
         OP_GROW: begin
            if (need > NEED_BITS'(lim_eff)) begin
               res_status_in = ST_NOSPACE;
            end else if (count_ff >= CNT_MAX) begin
               res_status_in = ST_FULL;
            end else begin
               wr_en           = 1'b1;
               wr_addr         = count_ff[IDX_BITS-1:0];
               wr_data.is_free = 1'b0;
               wr_data.size    = size_ff;
               wr_data.start   = brk_ff[ADDR_BITS-1:0];
               count_in        = count_ff + CNT_ONE;
               res_grant_in    = brk_ff[ADDR_BITS-1:0] + HDR;
               brk_in          = need[LIMIT_BITS-1:0];
            end
         end
         OP_RD_NEXT: begin
            rd_en     = idx_inc < count_ff;
            rd_addr   = idx_inc[IDX_BITS-1:0];
            rvalid_in = rd_en;
         end
         OP_CAP_NEXT: begin
            nxt_in = rd_data;
            mr_in  = rvalid_ff && rd_data.is_free;
         end
         OP_FREE_WR: begin
            // merged block goes to the left neighbour when that one is free
            wr_en           = 1'b1;
            wr_data.is_free = 1'b1;
            if (ml) begin
               wr_addr       = idx_dec[IDX_BITS-1:0];
               wr_data.size  = s_left;
               wr_data.start = prv_ff.start;
            end else begin
               wr_addr       = idx_ff[IDX_BITS-1:0];
               wr_data.size  = s_right;
               wr_data.start = cur_ff.start;
            end
            rd_idx_in   = idx_inc + CNT_BITS'(mr_ff);
            hi_in       = count_ff;
            dist_in     = 2'(ml) + 2'(mr_ff);
            shift_up_in = 1'b0;
            count_in    = count_ff - CNT_BITS'(ml) - CNT_BITS'(mr_ff);
         end
         OP_POST: begin
            rsp_valid_in                = 1'b1;
            rsp_data_in.status          = res_status_ff;
            rsp_data_in.granted_address = res_grant_ff;
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RST;
         count_ff     <= '0;
         brk_ff       <= '0;
         rvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         count_ff     <= count_in;
         brk_ff       <= brk_in;
         rvalid_ff    <= rvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      rd_idx_ff     <= rd_idx_in;
      dat_idx_ff    <= dat_idx_in;
      idx_ff        <= idx_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      dist_ff       <= dist_in;
      shift_up_ff   <= shift_up_in;
      mr_ff         <= mr_in;
      cur_ff        <= cur_in;
      prv_ff        <= prv_in;
      nxt_ff        <= nxt_in;
      res_status_ff <= res_status_in;
      res_grant_ff  <= res_grant_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

// ===== sv/first_fit_block_allocator.sv =====
// top level of the first-fit block allocator: controller, datapath and ports
`timescale 1ns / 1ps

// First-fit heap allocator over an address-ordered table of up to 64 blocks,
// each a 16-byte header and a payload. A request word allocates (first free
// block that fits, split when more than one header is left over and the
// table is not full, else growth at the break up to heap_limit) or frees
// (mark free and merge with free neighbours) and always returns exactly one
// response word. One request is worked at a time: the table lives in a
// single-read, single-write memory. A request goes through an accept step,
// a scan up to a matching row (or over all rows for a miss), then a grow
// step, or a split that moves the later table rows up, or a free that merges
// and moves rows down, and a post of the response. A new request is taken
// while the previous response still waits in its register. heap_limit may
// be written whenever no request is in flight.

module first_fit_block_allocator import ffa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ffa_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ffa_rsp_type           rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [LIMIT_BITS-1:0] csr_data
);

   ffa_cmd_type  cmd;
   ffa_stat_type stat;

   // sequencing
   ffa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // table, heap state and response word
   ffa_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule
